/* design/ptvt_pkg.sv */
`default_nettype none

package ptvt_pkg;

    // Pose table depth and the address bits that it needs
    localparam int BODY_COUNT = 256;
    localparam int BODY_IDX_W = $clog2(BODY_COUNT);

    // Transaction kinds on the input channel
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_XFORM = 1'b1;

    // Quaternion, Q1.15 components
    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic signed [15:0] w;
    } quat_t;

    // Three-component vector, Q16.16 components
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec3_t;

    // One pose table entry
    typedef struct packed {
        quat_t q;
        vec3_t p;
    } pose_t;

    // Rotation matrix, Q.28 entries
    typedef struct packed {
        logic signed [31:0] r00;
        logic signed [31:0] r01;
        logic signed [31:0] r02;
        logic signed [31:0] r10;
        logic signed [31:0] r11;
        logic signed [31:0] r12;
        logic signed [31:0] r20;
        logic signed [31:0] r21;
        logic signed [31:0] r22;
    } mat3_t;

    // Load enables of the pipeline stages; a stage loads when its slot is free
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
        logic s6;
    } pipe_en_t;

endpackage

`default_nettype wire

/* design/ptvt_pose_mem.sv */
`default_nettype none

module ptvt_pose_mem (
    input  wire logic                            aclk,
    input  wire logic                            wr_en,
    input  wire logic [ptvt_pkg::BODY_IDX_W-1:0] wr_addr,
    input  wire ptvt_pkg::pose_t                 wr_data,
    input  wire logic                            rd_en,
    input  wire logic [ptvt_pkg::BODY_IDX_W-1:0] rd_addr,
    output ptvt_pkg::pose_t                      rd_data
);

    ptvt_pkg::pose_t mem_reg [ptvt_pkg::BODY_COUNT];
    ptvt_pkg::pose_t rd_data_reg;

    // Write one pose entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read; hold the data while the stage stalls
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

/* design/ptvt_rot_matrix.sv */
`default_nettype none

module ptvt_rot_matrix (
    input  wire logic               aclk,
    input  wire ptvt_pkg::pipe_en_t en,
    input  wire ptvt_pkg::quat_t    quat,
    output ptvt_pkg::mat3_t         matrix
);

    localparam logic signed [33:0] ONE_Q30 = 34'sh040000000;

    logic signed [31:0] xx_reg, yy_reg, zz_reg;
    logic signed [31:0] xy_reg, xz_reg, yz_reg;
    logic signed [31:0] xw_reg, yw_reg, zw_reg;
    ptvt_pkg::mat3_t    mat_reg;
    ptvt_pkg::mat3_t    mat_next;

    // Round a Q.30 value to Q.28, half up
    function automatic logic signed [31:0] to_q28(input logic signed [33:0] q30);
        logic signed [33:0] t;
        t = q30 + 34'sd2;
        return $signed(t[33:2]);
    endfunction

    // Stage 2: form the component products, exact in Q.30
    always_ff @(posedge aclk) begin
        if (en.s2) begin
            xx_reg <= $signed(quat.x) * $signed(quat.x);
            yy_reg <= $signed(quat.y) * $signed(quat.y);
            zz_reg <= $signed(quat.z) * $signed(quat.z);
            xy_reg <= $signed(quat.x) * $signed(quat.y);
            xz_reg <= $signed(quat.x) * $signed(quat.z);
            yz_reg <= $signed(quat.y) * $signed(quat.z);
            xw_reg <= $signed(quat.x) * $signed(quat.w);
            yw_reg <= $signed(quat.y) * $signed(quat.w);
            zw_reg <= $signed(quat.z) * $signed(quat.w);
        end
    end

    // Build the matrix entries from the product pairs
    always_comb begin
        mat_next.r00 = to_q28(ONE_Q30 - ((34'(yy_reg) + 34'(zz_reg)) <<< 1));
        mat_next.r01 = to_q28((34'(xy_reg) - 34'(zw_reg)) <<< 1);
        mat_next.r02 = to_q28((34'(xz_reg) + 34'(yw_reg)) <<< 1);
        mat_next.r10 = to_q28((34'(xy_reg) + 34'(zw_reg)) <<< 1);
        mat_next.r11 = to_q28(ONE_Q30 - ((34'(xx_reg) + 34'(zz_reg)) <<< 1));
        mat_next.r12 = to_q28((34'(yz_reg) - 34'(xw_reg)) <<< 1);
        mat_next.r20 = to_q28((34'(xz_reg) - 34'(yw_reg)) <<< 1);
        mat_next.r21 = to_q28((34'(yz_reg) + 34'(xw_reg)) <<< 1);
        mat_next.r22 = to_q28(ONE_Q30 - ((34'(xx_reg) + 34'(yy_reg)) <<< 1));
    end

    // Stage 3: register the matrix
    always_ff @(posedge aclk) begin
        if (en.s3) begin
            mat_reg <= mat_next;
        end
    end

    assign matrix = mat_reg;

endmodule

`default_nettype wire

/* design/ptvt_vertex_mac.sv */
`default_nettype none

module ptvt_vertex_mac (
    input  wire logic               aclk,
    input  wire ptvt_pkg::pipe_en_t en,
    input  wire ptvt_pkg::mat3_t    matrix,
    input  wire ptvt_pkg::vec3_t    vertex,
    input  wire ptvt_pkg::vec3_t    position,
    output ptvt_pkg::vec3_t         world,
    output logic                    overflow
);

    localparam logic signed [63:0] ROUND_Q44 = 64'sd134217728;
    localparam logic signed [31:0] WORLD_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] WORLD_MIN = 32'sh80000000;

    logic signed [31:0] r     [9];
    logic signed [31:0] v     [3];
    logic signed [31:0] p     [3];
    logic signed [63:0] prod_reg [9];
    logic signed [31:0] pos_reg  [3];
    logic signed [63:0] a_reg    [3];
    logic signed [63:0] b_reg    [3];
    logic signed [63:0] acc      [3];
    logic signed [31:0] world_next [3];
    logic signed [31:0] world_reg  [3];
    logic               overflow_next;
    logic               overflow_reg;

    // Unpack matrix and vectors into indexable lanes
    always_comb begin
        r[0] = matrix.r00;
        r[1] = matrix.r01;
        r[2] = matrix.r02;
        r[3] = matrix.r10;
        r[4] = matrix.r11;
        r[5] = matrix.r12;
        r[6] = matrix.r20;
        r[7] = matrix.r21;
        r[8] = matrix.r22;
        v[0] = vertex.x;
        v[1] = vertex.y;
        v[2] = vertex.z;
        p[0] = position.x;
        p[1] = position.y;
        p[2] = position.z;
    end

    // Stage 4: one 32x32 product per matrix entry, Q.44
    always_ff @(posedge aclk) begin
        if (en.s4) begin
            for (int i = 0; i < 9; i++) begin
                prod_reg[i] <= 64'(r[i]) * 64'(v[i % 3]);
            end
            for (int i = 0; i < 3; i++) begin
                pos_reg[i] <= p[i];
            end
        end
    end

    // Stage 5: partial sums; fold the position and the rounding offset in
    always_ff @(posedge aclk) begin
        if (en.s5) begin
            for (int i = 0; i < 3; i++) begin
                a_reg[i] <= prod_reg[3*i] + prod_reg[3*i+1];
                b_reg[i] <= prod_reg[3*i+2] + (64'(pos_reg[i]) <<< 28) + ROUND_Q44;
            end
        end
    end

    // Final sum, drop to Q16.16, saturate each coordinate
    always_comb begin
        overflow_next = 1'b0;
        for (int i = 0; i < 3; i++) begin
            acc[i] = a_reg[i] + b_reg[i];
            if (acc[i][63:59] == {5{acc[i][59]}}) begin
                world_next[i] = $signed(acc[i][59:28]);
            end else begin
                world_next[i] = acc[i][63] ? WORLD_MIN : WORLD_MAX;
                overflow_next = 1'b1;
            end
        end
    end

    // Stage 6: output register
    always_ff @(posedge aclk) begin
        if (en.s6) begin
            for (int i = 0; i < 3; i++) begin
                world_reg[i] <= world_next[i];
            end
            overflow_reg <= overflow_next;
        end
    end

    assign world.x  = world_reg[0];
    assign world.y  = world_reg[1];
    assign world.z  = world_reg[2];
    assign overflow = overflow_reg;

endmodule

`default_nettype wire

/* design/pose_table_vertex_transform.sv */
// Rigid-body vertex transform with a 256-entry pose table. A load transaction
// (mode 0) writes one body's quaternion and position into the table and gives
// no result; a transform transaction (mode 1) reads the body's pose, rotates
// the local vertex by the quaternion's rotation matrix, adds the position and
// returns the world vertex saturated to Q16.16, with overflow set when any
// coordinate clipped. One transaction of either kind is taken every cycle
// while the front stage is free. The six register stages are the pose
// table read, the quaternion component products, the matrix, the 32x32
// multiplies, the partial sums, and the final sum with saturation in the
// output register. Each stage holds while the one after it is full and
// cannot move on, so input is taken as long as a pipeline slot is free even
// when a result waits. A load is seen by every transform accepted after it.
// The table is not cleared at reset: transform only bodies that were loaded.
`default_nettype none

module pose_table_vertex_transform (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_mode,
    input  wire logic [7:0]  s_body_index,
    input  wire logic [15:0] s_quat_x,
    input  wire logic [15:0] s_quat_y,
    input  wire logic [15:0] s_quat_z,
    input  wire logic [15:0] s_quat_w,
    input  wire logic [31:0] s_coord_x,
    input  wire logic [31:0] s_coord_y,
    input  wire logic [31:0] s_coord_z,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_world_x,
    output logic [31:0]      m_world_y,
    output logic [31:0]      m_world_z,
    output logic             m_overflow
);

    logic [6:1]          occ_reg;
    logic [6:1]          occ_next;
    logic [6:1]          free;
    ptvt_pkg::pipe_en_t  en;
    logic                in_range;
    logic                load_wr;
    ptvt_pkg::pose_t     wr_pose;
    ptvt_pkg::pose_t     rd_pose;
    ptvt_pkg::pose_t     pose1;
    ptvt_pkg::vec3_t     s_coord;
    ptvt_pkg::vec3_t     v1_reg, v2_reg, v3_reg;
    ptvt_pkg::vec3_t     p2_reg, p3_reg;
    logic                zero1_reg;
    ptvt_pkg::mat3_t     matrix;
    ptvt_pkg::vec3_t     world;

    // Free slot per stage: empty, or its contents move on this cycle
    always_comb begin
        free[6] = !occ_reg[6] || m_ready;
        for (int k = 5; k >= 1; k--) begin
            free[k] = !occ_reg[k] || free[k+1];
        end
    end

    assign s_ready = free[1];
    assign m_valid = occ_reg[6];

    assign en.s1 = free[1];
    assign en.s2 = free[2];
    assign en.s3 = free[3];
    assign en.s4 = free[4];
    assign en.s5 = free[5];
    assign en.s6 = free[6];

    // Advance occupancy; only transform transactions enter the pipeline
    always_comb begin
        occ_next = occ_reg;
        if (free[1]) begin
            occ_next[1] = s_valid && (s_mode == ptvt_pkg::MODE_XFORM);
        end
        for (int k = 2; k <= 6; k++) begin
            if (free[k]) begin
                occ_next[k] = occ_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // Pose table write on load
    assign in_range  = 32'(s_body_index) < 32'(ptvt_pkg::BODY_COUNT);
    assign load_wr   = s_valid && s_ready && (s_mode == ptvt_pkg::MODE_LOAD) && in_range;
    assign s_coord.x = s_coord_x;
    assign s_coord.y = s_coord_y;
    assign s_coord.z = s_coord_z;
    assign wr_pose.q.x = s_quat_x;
    assign wr_pose.q.y = s_quat_y;
    assign wr_pose.q.z = s_quat_z;
    assign wr_pose.q.w = s_quat_w;
    assign wr_pose.p   = s_coord;

    ptvt_pose_mem u_pose_mem (
        .aclk    (aclk),
        .wr_en   (load_wr),
        .wr_addr (s_body_index[ptvt_pkg::BODY_IDX_W-1:0]),
        .wr_data (wr_pose),
        .rd_en   (en.s1),
        .rd_addr (s_body_index[ptvt_pkg::BODY_IDX_W-1:0]),
        .rd_data (rd_pose)
    );

    // Stage 1: vertex and out-of-range flag beside the table read
    always_ff @(posedge aclk) begin
        if (en.s1) begin
            v1_reg    <= s_coord;
            zero1_reg <= !in_range;
        end
    end

    // Use an all-zero pose for an index beyond the table
    assign pose1 = zero1_reg ? '0 : rd_pose;

    // Carry vertex and position alongside the matrix build
    always_ff @(posedge aclk) begin
        if (en.s2) begin
            v2_reg <= v1_reg;
            p2_reg <= pose1.p;
        end
        if (en.s3) begin
            v3_reg <= v2_reg;
            p3_reg <= p2_reg;
        end
    end

    ptvt_rot_matrix u_rot_matrix (
        .aclk   (aclk),
        .en     (en),
        .quat   (pose1.q),
        .matrix (matrix)
    );

    ptvt_vertex_mac u_vertex_mac (
        .aclk     (aclk),
        .en       (en),
        .matrix   (matrix),
        .vertex   (v3_reg),
        .position (p3_reg),
        .world    (world),
        .overflow (m_overflow)
    );

    assign m_world_x = world.x;
    assign m_world_y = world.y;
    assign m_world_z = world.z;

`ifndef SYNTHESIS
    a_ready_when_front_empty: assert property (
        @(posedge aclk) disable iff (!aresetn)
        !occ_reg[1] |-> s_ready
    ) else $error("input stalled with an empty front stage");

    a_xform_enters: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_mode == ptvt_pkg::MODE_XFORM)) |=> occ_reg[1]
    ) else $error("accepted transform transaction did not enter the pipeline");

    a_load_no_result: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_mode == ptvt_pkg::MODE_LOAD)) |=> !occ_reg[1]
    ) else $error("load transaction entered the result pipeline");

    a_full_stalls_input: assert property (
        @(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready && (&occ_reg)) |-> !s_ready
    ) else $error("input accepted while every stage is full and stalled");
`endif

endmodule

`default_nettype wire
